// ===== src/lrupr_pkg.sv =====
// ---------------------------------------------------------------------------
// lrupr_pkg - shared types and constants for the LRU page replacement unit
// Port widths, parameter defaults and the control groups passed along the row.
// ---------------------------------------------------------------------------
package lrupr_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 16;
	localparam int unsigned PAGE_BITS_DEF   = 16;

	localparam int unsigned PAGE_W = 16;   // page_number / evicted_page port width
	localparam int unsigned SLOT_W = 4;    // slot_used port width
	localparam int unsigned CNT_W  = 32;   // request / fault counters
	localparam int unsigned CFG_W  = 5;    // active_entries register

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

	// flags of the search token travelling down the row
	typedef struct packed {
		logic valid;
		logic found;       // a hit has been seen upstream
		logic have_best;   // a victim candidate has been seen upstream
		logic best_valid;  // that candidate holds a valid page
	} tok_t;

	// update broadcast from the controller to every cell
	typedef struct packed {
		logic commit;
		logic miss;
	} upd_t;

endpackage

// ===== src/lrupr_cell.sv =====
// ---------------------------------------------------------------------------
// lrupr_cell - one cache slot of the LRU row
// Holds page, valid bit and recency rank; merges its slot into the passing
// search token and applies the recency update on commit.
// ---------------------------------------------------------------------------
module lrupr_cell
	import lrupr_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int unsigned PAGE_BITS   = PAGE_BITS_DEF,
	parameter int unsigned IDX         = 0,
	parameter int unsigned SW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	parameter int unsigned NW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] req_page,
	input  logic [NW-1:0]        active_n,
	input  upd_t                 upd,
	input  logic [SW-1:0]        upd_slot,
	input  logic [SW-1:0]        upd_rank,
	input  tok_t                 tok_in,
	input  logic [SW-1:0]        tok_in_hit_slot,
	input  logic [SW-1:0]        tok_in_hit_rank,
	input  logic [SW-1:0]        tok_in_best_slot,
	input  logic [SW-1:0]        tok_in_best_rank,
	input  logic [PAGE_BITS-1:0] tok_in_best_page,
	output tok_t                 tok_out,
	output logic [SW-1:0]        tok_out_hit_slot,
	output logic [SW-1:0]        tok_out_hit_rank,
	output logic [SW-1:0]        tok_out_best_slot,
	output logic [SW-1:0]        tok_out_best_rank,
	output logic [PAGE_BITS-1:0] tok_out_best_page
);

	localparam logic [SW-1:0] IDX_S    = SW'(IDX);
	localparam logic [NW-1:0] IDX_N    = NW'(IDX);
	localparam logic [SW-1:0] TOP_RANK = SW'(MAX_ENTRIES - 1);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [SW-1:0]        rank_q;

	tok_t                 tok_q;
	logic [SW-1:0]        hit_slot_q, hit_rank_q, best_slot_q, best_rank_q;
	logic [PAGE_BITS-1:0] best_page_q;

	logic active, take_hit, take_best, used;

	always_comb begin
		active    = (active_n > IDX_N);
		take_hit  = active && !tok_in.found && valid_q && (page_q == req_page);
		take_best = active && (!tok_in.have_best || (rank_q < tok_in_best_rank));
		used      = (upd_slot == IDX_S);
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= IDX_S;
		end else if (upd.commit) begin
			if (used) begin
				rank_q <= TOP_RANK;
				if (upd.miss) begin
					valid_q <= 1'b1;
				end
			end else if (rank_q > upd_rank) begin
				rank_q <= rank_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.commit && upd.miss && used) begin
			page_q <= req_page;
		end
	end

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid      <= tok_in.valid;
			tok_q.found      <= tok_in.found || take_hit;
			tok_q.have_best  <= tok_in.have_best || take_best;
			tok_q.best_valid <= take_best ? valid_q : tok_in.best_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_slot_q  <= take_hit  ? IDX_S  : tok_in_hit_slot;
		hit_rank_q  <= take_hit  ? rank_q : tok_in_hit_rank;
		best_slot_q <= take_best ? IDX_S  : tok_in_best_slot;
		best_rank_q <= take_best ? rank_q : tok_in_best_rank;
		best_page_q <= take_best ? page_q : tok_in_best_page;
	end

	assign tok_out           = tok_q;
	assign tok_out_hit_slot  = hit_slot_q;
	assign tok_out_hit_rank  = hit_rank_q;
	assign tok_out_best_slot = best_slot_q;
	assign tok_out_best_rank = best_rank_q;
	assign tok_out_best_page = best_page_q;

endmodule

// ===== src/lru_page_replacement_unit.sv =====
// ---------------------------------------------------------------------------
// lru_page_replacement_unit - fully associative page cache, LRU replacement
// Flow: one request in flight at a time; in_stall stays high until it is done. The search
// token walks the row of slot cells one cell per cycle, then comes a capture,
// a commit and a return to idle before the next accept. A result held by
// out_stall stretches the commit.
// Reset: all slots invalid, rank equals slot index, counters zero,
// active_entries = 16. No clearing pass; ready straight out of reset.
// ---------------------------------------------------------------------------
module lru_page_replacement_unit
	import lrupr_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int unsigned PAGE_BITS   = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: active_entries
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PAGE_W-1:0] page_number,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [SLOT_W-1:0] slot_used,
	output logic              evicted_valid,
	output logic [PAGE_W-1:0] evicted_page,
	output logic [CNT_W-1:0]  request_count,
	output logic [CNT_W-1:0]  fault_count
);

	localparam int unsigned SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned NW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     active_cfg_q;
	logic [PAGE_BITS-1:0] page_q;      // request page, broadcast to the row
	logic [NW-1:0]        active_n_q;  // clamped slot count for this request
	logic                 start_q;     // injects the token into cell 0

	// search result captured at the end of the row
	logic                 found_q, best_valid_q;
	logic [SW-1:0]        hit_slot_q, hit_rank_q, best_slot_q, best_rank_q;
	logic [PAGE_BITS-1:0] best_page_q;

	logic [CNT_W-1:0]     req_cnt_q, flt_cnt_q;

	logic                 out_valid_q, hit_q, ev_valid_q;
	logic [SLOT_W-1:0]    slot_used_q;
	logic [PAGE_W-1:0]    ev_page_q;

	// token chain: index 0 is the injection point, index MAX_ENTRIES the exit
	tok_t                 tok          [0:MAX_ENTRIES];
	logic [SW-1:0]        tok_hit_slot [0:MAX_ENTRIES];
	logic [SW-1:0]        tok_hit_rank [0:MAX_ENTRIES];
	logic [SW-1:0]        tok_best_slot[0:MAX_ENTRIES];
	logic [SW-1:0]        tok_best_rank[0:MAX_ENTRIES];
	logic [PAGE_BITS-1:0] tok_best_page[0:MAX_ENTRIES];

	upd_t                 upd;
	logic [SW-1:0]        upd_slot, upd_rank;
	logic                 out_free, accept, ev_valid;
	logic [NW-1:0]        active_n;
	logic [CNT_W-1:0]     req_cnt_next, flt_cnt_next;

	// clamp the register: zero acts as one, above the row size acts as full
	always_comb begin
		if (active_cfg_q == '0) begin
			active_n = NW'(1);
		end else if (32'(active_cfg_q) > MAX_ENTRIES) begin
			active_n = NW'(MAX_ENTRIES);
		end else begin
			active_n = NW'(active_cfg_q);
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// fresh token: nothing found, no victim candidate yet
	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = start_q;
		tok_hit_slot[0]  = '0;
		tok_hit_rank[0]  = '0;
		tok_best_slot[0] = '0;
		tok_best_rank[0] = '0;
		tok_best_page[0] = '0;
	end

	// commit: hit moves the slot to the top; miss fills the LRU victim
	always_comb begin
		upd.commit   = (state_q == ST_COMMIT) && out_free;
		upd.miss     = !found_q;
		upd_slot     = found_q ? hit_slot_q : best_slot_q;
		upd_rank     = found_q ? hit_rank_q : best_rank_q;
		ev_valid     = !found_q && best_valid_q;
		req_cnt_next = (req_cnt_q == '1) ? req_cnt_q : req_cnt_q + 1'b1;
		flt_cnt_next = (flt_cnt_q == '1 || found_q) ? flt_cnt_q : flt_cnt_q + 1'b1;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lrupr_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.PAGE_BITS   (PAGE_BITS),
			.IDX         (i),
			.SW          (SW),
			.NW          (NW)
		) u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.req_page          (page_q),
			.active_n          (active_n_q),
			.upd               (upd),
			.upd_slot          (upd_slot),
			.upd_rank          (upd_rank),
			.tok_in            (tok[i]),
			.tok_in_hit_slot   (tok_hit_slot[i]),
			.tok_in_hit_rank   (tok_hit_rank[i]),
			.tok_in_best_slot  (tok_best_slot[i]),
			.tok_in_best_rank  (tok_best_rank[i]),
			.tok_in_best_page  (tok_best_page[i]),
			.tok_out           (tok[i+1]),
			.tok_out_hit_slot  (tok_hit_slot[i+1]),
			.tok_out_hit_rank  (tok_hit_rank[i+1]),
			.tok_out_best_slot (tok_best_slot[i+1]),
			.tok_out_best_rank (tok_best_rank[i+1]),
			.tok_out_best_page (tok_best_page[i+1])
		);
	end

	// controller: state, request capture, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_cfg_q <= ACTIVE_RESET;
			page_q       <= '0;
			active_n_q   <= NW'(1);
			start_q      <= 1'b0;
			found_q      <= 1'b0;
			best_valid_q <= 1'b0;
			hit_slot_q   <= '0;
			hit_rank_q   <= '0;
			best_slot_q  <= '0;
			best_rank_q  <= '0;
			best_page_q  <= '0;
			req_cnt_q    <= '0;
			flt_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			hit_q        <= 1'b0;
			slot_used_q  <= '0;
			ev_valid_q   <= 1'b0;
			ev_page_q    <= '0;
		end else begin
			if (cfg_we) begin
				active_cfg_q <= cfg_wdata;
			end
			// result register: loaded on commit, emptied once taken
			if (upd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// token goes in the cycle after the accept (accept implies idle)
			start_q <= accept;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						page_q     <= PAGE_BITS'(page_number);
						active_n_q <= active_n;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[MAX_ENTRIES].valid) begin
						found_q      <= tok[MAX_ENTRIES].found;
						best_valid_q <= tok[MAX_ENTRIES].best_valid;
						hit_slot_q   <= tok_hit_slot[MAX_ENTRIES];
						hit_rank_q   <= tok_hit_rank[MAX_ENTRIES];
						best_slot_q  <= tok_best_slot[MAX_ENTRIES];
						best_rank_q  <= tok_best_rank[MAX_ENTRIES];
						best_page_q  <= tok_best_page[MAX_ENTRIES];
						state_q      <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						req_cnt_q   <= req_cnt_next;
						flt_cnt_q   <= flt_cnt_next;
						hit_q       <= found_q;
						slot_used_q <= SLOT_W'(upd_slot);
						ev_valid_q  <= ev_valid;
						ev_page_q   <= ev_valid ? PAGE_W'(best_page_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot_used     = slot_used_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign request_count = req_cnt_q;
	assign fault_count   = flt_cnt_q;

endmodule
